[design/png_scanline_unfilter_unit_assert.svh]
// Assertion macros for the checker file of the scanline unfilter unit
`ifndef PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PSU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psu check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psu check failed: next-cycle implication");

`endif

[design/psu_pkg.sv]
`timescale 1ns / 1ps

package psu_pkg;

  // Default sizes of the line store and the pixel windows
  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Field and register widths
  localparam int BYTE_W      = 8;
  localparam int BPP_W       = 4;
  localparam int ROW_BYTES_W = 14;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 14;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 4'd1;

  // Register reset values
  localparam logic [BPP_W-1:0]       BPP_RESET       = 4'd4;
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd4;

  // Filter type codes
  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

  // One reconstructed item
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_last;
    logic              bad_filter;
  } result_t;

  // Paeth predictor, unsigned: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic [BYTE_W+1:0] pa;
    logic [BYTE_W+1:0] pb;
    logic [BYTE_W+1:0] pc;
    logic [BYTE_W+1:0] ab;
    logic [BYTE_W+1:0] c2;
    pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
    pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
    ab = {2'b00, a} + {2'b00, b};
    c2 = {1'b0, c, 1'b0};
    pc = (ab > c2) ? ab - c2 : c2 - ab;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

[design/png_scanline_unfilter_unit.sv]
`timescale 1ns / 1ps

// PNG scanline unfilter: takes the inflated scanline stream one byte per item
// and returns one reconstructed sample per filtered byte (None, Sub, Up,
// Average or Paeth); the filter type byte at the head of each row yields no
// item, and in_tuser high marks the filter type byte of a new image. An item
// may be accepted every cycle while the skid stage is empty; its result enters
// the output register, or the skid stage while an output result waits.
// The previous row lives in a single-port-write line store of MAX_ROW_BYTES
// bytes, read ahead at the next column with a write bypass, so the
// store needs no clearing pass after reset. Filter types above 4 give zero
// bytes with out_tuser set. Write bytes_per_pixel (index 0) and row_bytes
// (index 1) only while the unit is idle.
module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [psu_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] data_byte
  input  logic                             in_tuser,   // [0] image_start
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [psu_pkg::BYTE_W-1:0]       out_tdata,  // [7:0] pixel_byte
  output logic                             out_tlast,  // row_last
  output logic                             out_tuser,  // [0] bad_filter
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W = (COL_W + 1 > psu_pkg::ROW_BYTES_W) ? COL_W + 1 : psu_pkg::ROW_BYTES_W;
  localparam int WIN_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam logic [LEN_W-1:0]             MAX_LEN = LEN_W'(MAX_ROW_BYTES);
  localparam logic [psu_pkg::BPP_W-1:0]    MAX_BPP = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);

  // configuration registers
  logic [psu_pkg::BPP_W-1:0]       bpp_r;
  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_r;

  // row state
  logic [COL_W-1:0]            column_r,     column_nxt;
  logic [psu_pkg::BYTE_W-1:0]  row_filter_r, row_filter_nxt;
  logic                        first_row_r,  first_row_nxt;
  logic                        await_filter_r, await_filter_nxt;

  // windows of the current row
  logic [psu_pkg::BYTE_W-1:0]  left_win_r   [MAX_PIXEL_BYTES];
  logic [psu_pkg::BYTE_W-1:0]  upleft_win_r [MAX_PIXEL_BYTES];

  // line store and its read path
  logic [psu_pkg::BYTE_W-1:0]  line_mem [MAX_ROW_BYTES];
  logic [psu_pkg::BYTE_W-1:0]  line_q_r;
  logic                        byp_hit_r;
  logic [psu_pkg::BYTE_W-1:0]  byp_data_r;
  logic [psu_pkg::BYTE_W-1:0]  line_rd;

  // output register and skid stage
  psu_pkg::result_t            out_r, skid_r, res;
  logic                        out_valid_r, skid_valid_r;

  // datapath
  logic                        accept, take_filter, sample;
  logic [psu_pkg::BPP_W-1:0]   bpp_eff;
  logic [LEN_W-1:0]            rlen, col_ext, col_inc;
  logic [WIN_W-1:0]            win_idx;
  logic                        has_left, last, bad;
  logic [psu_pkg::BYTE_W-1:0]  a, b, c, px;
  logic [psu_pkg::BYTE_W:0]    ab_sum;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= psu_pkg::BPP_RESET;
      row_bytes_r <= psu_pkg::ROW_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psu_pkg::REG_BYTES_PER_PIXEL: bpp_r       <= cfg_data[psu_pkg::BPP_W-1:0];
        psu_pkg::REG_ROW_BYTES:       row_bytes_r <= cfg_data[psu_pkg::ROW_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: a waiting skid item stops input
  assign in_tready   = !skid_valid_r;
  assign accept      = in_tvalid && in_tready;
  assign take_filter = in_tuser || await_filter_r;
  assign sample      = accept && !take_filter;

  // clamp pixel size and row length
  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp_r > MAX_BPP) begin
      bpp_eff = MAX_BPP;
    end else begin
      bpp_eff = bpp_r;
    end
    rlen = LEN_W'(row_bytes_r);
    if (rlen == '0) begin
      rlen = LEN_W'(1);
    end else if (rlen > MAX_LEN) begin
      rlen = MAX_LEN;
    end
  end

  // neighbours of the current sample
  assign win_idx  = WIN_W'(bpp_eff - psu_pkg::BPP_W'(1));
  assign col_ext  = LEN_W'(column_r);
  assign col_inc  = col_ext + LEN_W'(1);
  assign has_left = col_ext >= LEN_W'(bpp_eff);
  assign line_rd  = byp_hit_r ? byp_data_r : line_q_r;
  assign a        = has_left ? left_win_r[win_idx] : '0;
  assign b        = first_row_r ? '0 : line_rd;
  assign c        = (has_left && !first_row_r) ? upleft_win_r[win_idx] : '0;
  assign ab_sum   = {1'b0, a} + {1'b0, b};
  assign last     = col_inc >= rlen;

  // reconstruct one byte
  always_comb begin
    bad = 1'b0;
    unique case (row_filter_r)
      psu_pkg::FILT_NONE:  px = in_tdata;
      psu_pkg::FILT_SUB:   px = in_tdata + a;
      psu_pkg::FILT_UP:    px = in_tdata + b;
      psu_pkg::FILT_AVG:   px = in_tdata + ab_sum[psu_pkg::BYTE_W:1];
      psu_pkg::FILT_PAETH: px = in_tdata + psu_pkg::paeth_pick(a, b, c);
      default: begin
        px  = '0;
        bad = 1'b1;
      end
    endcase
  end

  assign res.pixel_byte = px;
  assign res.row_last   = last;
  assign res.bad_filter = bad;

  // advance row state
  always_comb begin
    column_nxt       = column_r;
    row_filter_nxt   = row_filter_r;
    first_row_nxt    = first_row_r;
    await_filter_nxt = await_filter_r;
    if (accept && take_filter) begin
      row_filter_nxt   = in_tdata;
      await_filter_nxt = 1'b0;
      column_nxt       = '0;
      if (in_tuser) begin
        first_row_nxt = 1'b1;
      end
    end else if (sample) begin
      if (last) begin
        column_nxt       = '0;
        await_filter_nxt = 1'b1;
        first_row_nxt    = 1'b0;
      end else begin
        column_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r       <= '0;
      row_filter_r   <= '0;
      first_row_r    <= 1'b1;
      await_filter_r <= 1'b1;
      byp_hit_r      <= 1'b0;
    end else begin
      column_r       <= column_nxt;
      row_filter_r   <= row_filter_nxt;
      first_row_r    <= first_row_nxt;
      await_filter_r <= await_filter_nxt;
      byp_hit_r      <= sample && (column_r == column_nxt);
    end
  end

  // line store: write this column, read ahead at the next one
  always_ff @(posedge clk) begin
    if (sample) begin
      line_mem[column_r] <= px;
    end
    line_q_r   <= line_mem[column_nxt];
    byp_data_r <= px;
  end

  // clear the windows at a filter byte, shift them on each sample
  always_ff @(posedge clk) begin
    if (accept && take_filter) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_win_r[i]   <= '0;
        upleft_win_r[i] <= '0;
      end
    end else if (sample) begin
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_win_r[i]   <= left_win_r[i-1];
        upleft_win_r[i] <= upleft_win_r[i-1];
      end
      left_win_r[0]   <= px;
      upleft_win_r[0] <= b;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= sample;
      end
    end else if (sample) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (sample) begin
        out_r <= res;
      end
    end else if (sample) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.pixel_byte;
  assign out_tlast  = out_r.row_last;
  assign out_tuser  = out_r.bad_filter;

endmodule

[design/psu_checker.sv]
`timescale 1ns / 1ps

`include "png_scanline_unfilter_unit_assert.svh"

module psu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // hold a stalled result item
  `PSU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable({out_tdata, out_tlast, out_tuser}))

  // an unknown filter type gives zero bytes
  `PSU_ASSERT_IMPLY(a_bad_is_zero, out_tvalid && out_tuser, out_tdata == 8'd0)

  // input only stops while a result item waits at the output
  `PSU_ASSERT_IMPLY(a_stall_has_item, !in_tready, out_tvalid)

endmodule

bind png_scanline_unfilter_unit psu_checker u_psu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
